### rtl/fcv_pkg.sv
package fcv_pkg;

   // Widths fixed by the item and register layout.
   localparam int MaxTaps     = 32;
   localparam int SampleW     = 8;
   localparam int FracBits    = 5;
   localparam int ProdW       = 2 * SampleW;
   localparam int TapCntW     = 6;
   localparam int TailW       = $clog2(MaxTaps);
   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = 64;
   localparam int CoefWords   = 4;
   localparam int CoefPerWord = CsrDataW / SampleW;
   localparam int LaneGroup   = 8;

   // Queue depths between the parts of the block.
   localparam int InDepth  = 4;
   localparam int OutDepth = 8;
   localparam int OutCntW  = $clog2(OutDepth + 1);

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CsrTapCount  = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrCoefWord0 = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrCoefWord1 = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrCoefWord2 = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrCoefWord3 = 3'd4;

   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic                      final_sample;
   } req_item_type;

   typedef struct packed {
      logic signed [SampleW-1:0] filtered;
      logic                      end_of_signal;
   } rsp_item_type;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      logic signed [SampleW-1:0] sample;
      logic                      final_sample;
      logic [TailW-1:0]          tail_len;
   } job_type;

endpackage

### rtl/fcv_fifo.sv
module fcv_fifo #(
   parameter type entry_type = logic,
   parameter int  Depth      = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  entry_type                    wr_data,
   output logic                         full,
   input  logic                         pop,
   output logic                         empty,
   output entry_type                    rd_data,
   output logic [$clog2(Depth+1)-1:0]   count
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/fcv_front.sv
module fcv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  fcv_pkg::req_item_type         req_item,
   output logic                          req_full,
   input  logic [fcv_pkg::TapCntW-1:0]   taps_used,
   input  logic                          job_pop,
   output logic                          job_empty,
   output fcv_pkg::job_type              job
);

   import fcv_pkg::*;

   job_type job_in;

   // A final sample carries the number of tail outputs it still owes.
   always_comb begin
      job_in.sample       = req_item.sample;
      job_in.final_sample = req_item.final_sample;
      job_in.tail_len     = req_item.final_sample ?
                            TailW'(taps_used - TapCntW'(1)) : '0;
   end

   fcv_fifo #(
      .entry_type (job_type),
      .Depth      (InDepth)
   ) u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (job_in),
      .full    (req_full),
      .pop     (job_pop),
      .empty   (job_empty),
      .rd_data (job),
      .count   ()
   );

endmodule

### rtl/fcv_back.sv
module fcv_back #(
   parameter int TAPS = fcv_pkg::MaxTaps
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       job_empty,
   input  fcv_pkg::job_type                           job,
   output logic                                       job_pop,
   input  logic [TAPS-1:0][fcv_pkg::SampleW-1:0]      coefs,
   input  logic [fcv_pkg::TapCntW-1:0]                taps_used,
   input  logic [fcv_pkg::OutCntW-1:0]                out_count,
   output logic                                       rsp_push,
   output fcv_pkg::rsp_item_type                      rsp_item
);

   import fcv_pkg::*;

   localparam int Groups = (TAPS + LaneGroup - 1) / LaneGroup;

   logic [TailW-1:0]               tail_left_ff, tail_left_in;
   logic [TAPS-1:0][SampleW-1:0]   line_ff, line_in, shifted;
   logic signed [ProdW-1:0]        prod [TAPS];
   logic [TAPS-1:0][SampleW-1:0]   term_in, term_ff;
   logic [Groups-1:0][SampleW-1:0] group_in, group_ff;
   logic [SampleW-1:0]             total_in, total_ff;
   logic                           v1_ff, v2_ff, v3_ff;
   logic                           eos1_ff, eos2_ff, eos3_ff;
   logic                           issue, eos, room;
   logic [SampleW-1:0]             shift_val;
   logic [1:0]                     inflight;

   // Issue only when the result queue has a slot for every output in flight.
   always_comb begin
      inflight = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);
      room     = (out_count + OutCntW'(inflight)) < OutCntW'(OutDepth);
   end

   // Tail outputs of a finished signal take priority over the next item.
   always_comb begin
      job_pop      = 1'b0;
      issue        = 1'b0;
      eos          = 1'b0;
      shift_val    = '0;
      tail_left_in = tail_left_ff;
      if (room) begin
         if (tail_left_ff != '0) begin
            issue        = 1'b1;
            eos          = (tail_left_ff == TailW'(1));
            tail_left_in = tail_left_ff - TailW'(1);
         end else if (!job_empty) begin
            issue     = 1'b1;
            job_pop   = 1'b1;
            shift_val = job.sample;
            if (job.tail_len == '0) begin
               eos = job.final_sample;
            end else begin
               tail_left_in = job.tail_len;
            end
         end
      end
   end

   always_comb begin
      shifted[0] = shift_val;
      for (int k = 1; k < TAPS; k++) begin
         shifted[k] = line_ff[k-1];
      end
      line_in = line_ff;
      if (issue) begin
         line_in = eos ? '0 : shifted;
      end
   end

   // Each lane keeps bits 12..5 of its product: floor to Q3.5, modulo 256.
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod[k]    = $signed(shifted[k]) * $signed(coefs[k]);
         term_in[k] = (TapCntW'(k) < taps_used) ?
                      prod[k][FracBits+SampleW-1:FracBits] : '0;
      end
   end

   always_comb begin
      for (int g = 0; g < Groups; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < LaneGroup; j++) begin
            if (g * LaneGroup + j < TAPS) begin
               group_in[g] = group_in[g] + term_ff[g*LaneGroup+j];
            end
         end
      end
      total_in = '0;
      for (int g = 0; g < Groups; g++) begin
         total_in = total_in + group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_left_ff <= '0;
         line_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         tail_left_ff <= tail_left_in;
         line_ff      <= line_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      term_ff  <= term_in;
      eos1_ff  <= eos;
      group_ff <= group_in;
      eos2_ff  <= eos1_ff;
      total_ff <= total_in;
      eos3_ff  <= eos2_ff;
   end

   assign rsp_push               = v3_ff;
   assign rsp_item.filtered      = total_ff;
   assign rsp_item.end_of_signal = eos3_ff;

endmodule

### rtl/fir_full_convolution_q3_5_unit.sv
// Full linear convolution of a signed Q3.5 sample stream with up to TAPS
// signed Q3.5 coefficients, with wrapping 8-bit accumulation.
// Input items are pushed with req_push while req_full is low. Each item
// gives one result; an item with final_sample set also gives taps_used-1
// tail results, and the last result of the signal has end_of_signal set.
// The delay line is then cleared, so the next item starts a new signal.
// Results are read like a queue: the oldest one sits on rsp_item while
// rsp_empty is low and leaves when rsp_pop is high.
// While the result queue has room, an item is taken and one result is
// produced every cycle; a final item holds the back end until its tail
// results are issued. After the edge that accepts an item, its first
// result reaches rsp_item through the back end, where products, partial
// sums and total each take one register, and the result queue write.
// When the receiver stalls, the back end stops issuing once the result
// queue cannot hold all outputs in flight, then the input queue fills and
// req_full rises. Nothing is ever dropped.
// Reset empties both queues, clears the delay line, sets tap_count to one
// and all coefficients to zero. The user writes registers through csr_we,
// csr_index and csr_wdata only while the block is idle; not enforced.
module fir_full_convolution_q3_5_unit #(
   parameter int TAPS = fcv_pkg::MaxTaps
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  fcv_pkg::req_item_type          req_item,
   output logic                           req_full,
   input  logic                           rsp_pop,
   output fcv_pkg::rsp_item_type          rsp_item,
   output logic                           rsp_empty,
   input  logic                           csr_we,
   input  logic [fcv_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [fcv_pkg::CsrDataW-1:0]   csr_wdata
);

   import fcv_pkg::*;

   logic [TapCntW-1:0]              tap_count_ff;
   logic [CoefWords-1:0][CsrDataW-1:0] coef_ff;
   logic [TapCntW-1:0]              taps_used;
   logic [TAPS-1:0][SampleW-1:0]    coefs;
   logic                            job_empty, job_pop;
   job_type                         job;
   logic                            rsp_push;
   rsp_item_type                    rsp_in;
   logic [OutCntW-1:0]              out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TapCntW'(1);
         coef_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrTapCount:  tap_count_ff <= csr_wdata[TapCntW-1:0];
            CsrCoefWord0: coef_ff[0]   <= csr_wdata;
            CsrCoefWord1: coef_ff[1]   <= csr_wdata;
            CsrCoefWord2: coef_ff[2]   <= csr_wdata;
            CsrCoefWord3: coef_ff[3]   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A tap count of zero acts as one; counts above TAPS saturate.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_used = TapCntW'(1);
      end else if (tap_count_ff > TapCntW'(TAPS)) begin
         taps_used = TapCntW'(TAPS);
      end else begin
         taps_used = tap_count_ff;
      end
   end

   for (genvar k = 0; k < TAPS; k++) begin : g_coef
      assign coefs[k] = coef_ff[k/CoefPerWord][(k%CoefPerWord)*SampleW +: SampleW];
   end

   fcv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .taps_used (taps_used),
      .job_pop   (job_pop),
      .job_empty (job_empty),
      .job       (job)
   );

   fcv_back #(
      .TAPS (TAPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job),
      .job_pop   (job_pop),
      .coefs     (coefs),
      .taps_used (taps_used),
      .out_count (out_count),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in)
   );

   // The back end only issues when a slot is reserved, so this queue never
   // overflows and its full flag is not needed.
   fcv_fifo #(
      .entry_type (rsp_item_type),
      .Depth      (OutDepth)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_item),
      .count   (out_count)
   );

endmodule
